// ===== hw/rtl/fspc_pkg.sv =====
// Shared types and constants for the fuzzy speed PWM controller.
// No dependencies; imported by every module of the block.
package fspc_pkg;

  localparam int NSETS     = 5;
  localparam int DEG_W     = 8;                 // degrees 0..250
  localparam int DEN_W     = 11;                // sum of five degrees, <= 1250
  localparam int NUM_W     = 16;                // |weighted sum| <= 50 * 1250
  localparam int QBITS     = 6;                 // quotient magnitude <= 50
  localparam int QIDX_W    = 3;
  localparam int HALF_BASE = 25;
  localparam int SLOPE     = 10;

  localparam logic [DEG_W-1:0]  DEG_FULL = 8'd250;
  localparam logic signed [15:0] SET_LOW  = -16'sd50;
  localparam logic signed [15:0] SET_HIGH = 16'sd50;

  // output set selected by (error set, change set)
  localparam logic [2:0] RULE_OUT [NSETS][NSETS] = '{
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2},
    '{3'd0, 3'd1, 3'd1, 3'd2, 3'd3},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
    '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4},
    '{3'd2, 3'd3, 3'd3, 3'd4, 3'd4}
  };

  typedef logic [NSETS-1:0][DEG_W-1:0] deg_vec_t;

  // one request in flight through the divider
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QBITS-1:0] quo;
    logic             neg;
  } div_st_t;

endpackage

// ===== hw/rtl/fspc_front.sv =====
// Front end: takes a request, fuzzifies both inputs, evaluates the rule base
// and forms centroid numerator/denominator. Depends on fspc_pkg.
module fspc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_speed_error,
  input  logic signed [15:0]   in_error_change,
  output logic                 wr_valid,
  input  logic                 wr_ready,
  output fspc_pkg::div_st_t    wr_st
);
  import fspc_pkg::*;

  function automatic deg_vec_t fuzzify(logic signed [15:0] x);
    deg_vec_t         d;
    logic signed [15:0] off_w;
    logic [6:0]       off;
    logic [6:0]       lo;
    d     = '0;
    off_w = x - SET_LOW;
    off   = off_w[6:0];
    if (x <= SET_LOW) begin
      d[0] = DEG_FULL;
    end else if (x > SET_HIGH) begin
      d[NSETS-1] = DEG_FULL;
    end else begin
      for (int i = 1; i < NSETS; i++) begin
        lo = 7'(HALF_BASE * (i - 1));
        if (off > lo && off <= lo + 7'(HALF_BASE)) begin
          d[i]   = 8'(off - lo) * 8'(SLOPE);
          d[i-1] = DEG_FULL - d[i];
        end
      end
    end
    return d;
  endfunction

  logic     f_valid_r;
  deg_vec_t de_r, dc_r;
  deg_vec_t de_nxt, dc_nxt;
  deg_vec_t dout;
  logic [DEG_W-1:0] m;
  logic signed [12:0] wsum;
  logic [11:0] wmag;
  logic [16:0] nprod;

  assign de_nxt   = fuzzify(in_speed_error);
  assign dc_nxt   = fuzzify(in_error_change);
  assign in_ready = !f_valid_r || wr_ready;
  assign wr_valid = f_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      de_r <= de_nxt;
      dc_r <= dc_nxt;
    end
  end

  // min-AND per rule, max-OR into the output sets
  always_comb begin
    dout = '0;
    m    = '0;
    for (int a = 0; a < NSETS; a++) begin
      for (int b = 0; b < NSETS; b++) begin
        m = (de_r[a] < dc_r[b]) ? de_r[a] : dc_r[b];
        if (dout[RULE_OUT[a][b]] < m) dout[RULE_OUT[a][b]] = m;
      end
    end
  end

  // peaks are 25 * {-2,-1,0,1,2}; the factor 25 is applied to the magnitude
  always_comb begin
    wsum = 13'(dout[3]) + (13'(dout[4]) <<< 1) - 13'(dout[1]) - (13'(dout[0]) <<< 1);
    wmag = wsum[12] ? 12'(-wsum) : 12'(wsum);
    nprod = 17'(wmag) * 17'(HALF_BASE);
    wr_st.rem = nprod[NUM_W-1:0];
    wr_st.den = DEN_W'(dout[0]) + DEN_W'(dout[1]) + DEN_W'(dout[2])
              + DEN_W'(dout[3]) + DEN_W'(dout[4]);
    wr_st.quo = '0;
    wr_st.neg = wsum[12];
  end

endmodule

// ===== hw/rtl/fspc_queue.sv =====
// Two-entry flop queue between the front end and the divider.
// Depends on fspc_pkg.
module fspc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  fspc_pkg::div_st_t  wr_st,
  output logic               rd_valid,
  input  logic               rd_ready,
  output fspc_pkg::div_st_t  rd_st
);
  import fspc_pkg::*;

  div_st_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_st    = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 2'd1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_st;
  end

endmodule

// ===== hw/rtl/fspc_div.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage,
// then sign and output register. Depends on fspc_pkg.
module fspc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fspc_pkg::div_st_t  in_st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [6:0]  out_pwm_delta
);
  import fspc_pkg::*;

  localparam int NSTG = QBITS - 1;   // bit 0 is resolved into the output register

  function automatic div_st_t div_step(div_st_t s, logic [QIDX_W-1:0] b);
    div_st_t          r;
    logic [NUM_W-1:0] dsh;
    r   = s;
    dsh = NUM_W'(s.den) << b;
    if (s.rem >= dsh) begin
      r.rem    = s.rem - dsh;
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  logic [NSTG-1:0] v_r;
  div_st_t         st_r   [NSTG];
  div_st_t         st_nxt [NSTG];
  logic [NSTG-1:0] src_valid;
  logic [NSTG:0]   adv;
  logic            out_valid_r;
  logic signed [6:0] pwm_r, pwm_nxt;
  div_st_t         fin;
  logic [6:0]      mag7;

  always_comb begin
    adv[NSTG] = !out_valid_r || out_ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  always_comb begin
    src_valid[0] = in_valid;
    st_nxt[0]    = div_step(in_st, QIDX_W'(QBITS - 1));
    for (int s = 1; s < NSTG; s++) begin
      src_valid[s] = v_r[s-1];
      st_nxt[s]    = div_step(st_r[s-1], QIDX_W'(QBITS - 1 - s));
    end
  end

  always_comb begin
    fin     = div_step(st_r[NSTG-1], '0);
    mag7    = {1'b0, fin.quo};
    pwm_nxt = fin.neg ? $signed(~mag7 + 7'd1) : $signed(mag7);
  end

  assign in_ready      = adv[0];
  assign out_valid     = out_valid_r;
  assign out_pwm_delta = pwm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (adv[s]) v_r[s] <= src_valid[s];
      end
      if (adv[NSTG]) out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (adv[s] && src_valid[s]) st_r[s] <= st_nxt[s];
    end
    if (adv[NSTG] && v_r[NSTG-1]) pwm_r <= pwm_nxt;
  end

endmodule

// ===== hw/rtl/fuzzy_speed_pwm_controller.sv =====
// Fuzzy PD speed controller: speed error and error change in, PWM duty change
// out. One request per cycle is sustained when the output side does not stall.
// The centroid divider is a six-stage restoring pipeline resolving one quotient
// bit per stage, behind a fuzzify/rule stage and a two-entry queue that lets
// the front end keep accepting while the divider is held by the output.
// Depends on fspc_pkg, fspc_front, fspc_queue and fspc_div.
module fuzzy_speed_pwm_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_speed_error,
  input  logic signed [15:0] in_error_change,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [6:0]  out_pwm_delta
);
  import fspc_pkg::*;

  logic    fq_valid, fq_ready;
  div_st_t fq_st;
  logic    qd_valid, qd_ready;
  div_st_t qd_st;

  fspc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_speed_error  (in_speed_error),
    .in_error_change (in_error_change),
    .wr_valid        (fq_valid),
    .wr_ready        (fq_ready),
    .wr_st           (fq_st)
  );

  fspc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_st    (fq_st),
    .rd_valid (qd_valid),
    .rd_ready (qd_ready),
    .rd_st    (qd_st)
  );

  fspc_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (qd_valid),
    .in_ready      (qd_ready),
    .in_st         (qd_st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pwm_delta (out_pwm_delta)
  );

endmodule
